// ===== sv/surface_command_selector_limiter_unit_macros.svh =====
// assertion macros for the surface command selector limiter
`ifndef SURFACE_COMMAND_SELECTOR_LIMITER_UNIT_MACROS_SVH
`define SURFACE_COMMAND_SELECTOR_LIMITER_UNIT_MACROS_SVH

// property checked on every clock edge outside reset
`define SCSL_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition in one cycle implies a condition in the next
`define SCSL_ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

// ===== sv/scsl_pkg.sv =====
// shared types and constants of the surface command selector limiter
package scsl_pkg;

    localparam int LIMIT_W    = 15;
    localparam int TOL_W      = 16;
    localparam int INV_W      = 16;
    localparam int DT_W       = 16;
    localparam int FLAGS_W    = 8;
    localparam int ERR_W      = 16;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 16;
    localparam int NUM_LANES  = 3;

    localparam int LANE_STAB   = 0;
    localparam int LANE_FLAP   = 1;
    localparam int LANE_RUDDER = 2;

    // status flag bit positions
    localparam int FLAG_AOA      = 0;
    localparam int FLAG_NZ       = 1;
    localparam int FLAG_RATE     = 2;
    localparam int FLAG_LAW_SAT  = 3;
    localparam int FLAG_ACT_SAT  = 4;
    localparam int FLAG_STAB_LIM = 5;
    localparam int FLAG_DIR_LO   = 6;

    localparam logic [1:0] DIR_NEG = 2'd1;
    localparam logic [1:0] DIR_POS = 2'd2;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_STAB_LIMIT   = 3'd0,
        REG_FLAP_LIMIT   = 3'd1,
        REG_RUDDER_LIMIT = 3'd2,
        REG_TRACK_TOL    = 3'd3,
        REG_INV_BLEND    = 3'd4
    } cfg_reg_t;

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_INC  = 6'b000010,
        ST_FRAC = 6'b000100,
        ST_PROD = 6'b001000,
        ST_LANE = 6'b010000,
        ST_OUT  = 6'b100000
    } seq_state_t;

    typedef struct packed {
        logic capture_src;
        logic mul_en;
        logic fin_en;
    } lane_ctrl_t;

    typedef struct packed {
        logic limited;
        logic cmd_le_pos;
        logic cmd_ge_pos;
    } lane_flag_t;

endpackage

// ===== sv/scsl_in_if.sv =====
// input channel of the surface command selector limiter
interface scsl_in_if #(
    parameter int ANGLE_WIDTH = 16
);
    logic                               valid;
    logic                               ready;
    logic                               law_select;
    logic signed [ANGLE_WIDTH-1:0]      norm_stab;
    logic signed [ANGLE_WIDTH-1:0]      norm_flap;
    logic signed [ANGLE_WIDTH-1:0]      norm_rudder;
    logic signed [ANGLE_WIDTH-1:0]      dir_stab;
    logic signed [ANGLE_WIDTH-1:0]      dir_flap;
    logic signed [ANGLE_WIDTH-1:0]      dir_rudder;
    logic signed [ANGLE_WIDTH-1:0]      pos_stab;
    logic signed [ANGLE_WIDTH-1:0]      pos_flap;
    logic signed [ANGLE_WIDTH-1:0]      pos_rudder;
    logic [scsl_pkg::DT_W-1:0]          frame_time;
    logic [scsl_pkg::FLAGS_W-1:0]       status_flags;

    modport source (
        output valid, law_select, norm_stab, norm_flap, norm_rudder,
               dir_stab, dir_flap, dir_rudder, pos_stab, pos_flap, pos_rudder,
               frame_time, status_flags,
        input  ready
    );

    modport sink (
        input  valid, law_select, norm_stab, norm_flap, norm_rudder,
               dir_stab, dir_flap, dir_rudder, pos_stab, pos_flap, pos_rudder,
               frame_time, status_flags,
        output ready
    );
endinterface

// ===== sv/scsl_out_if.sv =====
// result channel of the surface command selector limiter
interface scsl_out_if #(
    parameter int ANGLE_WIDTH = 16
);
    logic                               valid;
    logic                               ready;
    logic signed [ANGLE_WIDTH-1:0]      cmd_stab;
    logic signed [ANGLE_WIDTH-1:0]      cmd_flap;
    logic signed [ANGLE_WIDTH-1:0]      cmd_rudder;
    logic                               active_law;
    logic                               in_transition;
    logic                               elec_saturated;
    logic                               act_saturated;
    logic                               protect_exhausted;
    logic                               tracking_ok;
    logic [scsl_pkg::ERR_W-1:0]         max_track_error;
    logic                               frame_error;

    modport source (
        output valid, cmd_stab, cmd_flap, cmd_rudder, active_law, in_transition,
               elec_saturated, act_saturated, protect_exhausted, tracking_ok,
               max_track_error, frame_error,
        input  ready
    );

    modport sink (
        input  valid, cmd_stab, cmd_flap, cmd_rudder, active_law, in_transition,
               elec_saturated, act_saturated, protect_exhausted, tracking_ok,
               max_track_error, frame_error,
        output ready
    );
endinterface

// ===== sv/scsl_lane.sv =====
// one surface lane: blend toward target, clamp to limit, tracking error
module scsl_lane #(
    parameter int ANGLE_WIDTH   = 16,
    parameter int FRACTION_BITS = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  scsl_pkg::lane_ctrl_t              ctrl,
    input  logic signed [ANGLE_WIDTH-1:0]     target,
    input  logic signed [ANGLE_WIDTH-1:0]     pos,
    input  logic [FRACTION_BITS:0]            frac,
    input  logic [scsl_pkg::LIMIT_W-1:0]      limit,
    output logic signed [ANGLE_WIDTH-1:0]     cmd,
    output logic [ANGLE_WIDTH:0]              err,
    output scsl_pkg::lane_flag_t              flag
);
    import scsl_pkg::*;

    localparam int AW = ANGLE_WIDTH;
    localparam int FB = FRACTION_BITS;
    localparam int PW = AW + FB + 3;
    localparam int CW = ((AW > LIMIT_W) ? AW : LIMIT_W) + 2;

    logic signed [AW-1:0]   src_reg;
    logic signed [AW-1:0]   dem_reg;
    logic signed [PW-1:0]   prod_reg;
    logic signed [AW-1:0]   cmd_reg;
    logic [AW:0]            err_reg;
    lane_flag_t             flag_reg;

    logic signed [AW:0]     diff;
    logic signed [FB+1:0]   frac_s;
    logic signed [PW-1:0]   prod_next;
    logic signed [PW-1:0]   quot;
    logic signed [AW:0]     dem_wide;
    logic signed [AW-1:0]   dem_next;
    logic signed [CW-1:0]   dem_c;
    logic signed [CW-1:0]   lim_c;
    logic signed [CW-1:0]   neg_lim;
    logic signed [CW-1:0]   clamp_c;
    logic signed [AW-1:0]   cmd_next;
    logic signed [AW:0]     cmd_e;
    logic signed [AW:0]     pos_e;
    logic signed [AW:0]     delta;
    logic [AW:0]            err_next;

    assign diff      = $signed({target[AW-1], target}) - $signed({src_reg[AW-1], src_reg});
    assign frac_s    = $signed({1'b0, frac});
    assign prod_next = PW'(diff) * PW'(frac_s);

    // arithmetic shift floors toward minus infinity
    assign quot      = prod_reg >>> FB;
    assign dem_wide  = $signed({src_reg[AW-1], src_reg}) + $signed(quot[AW:0]);
    assign dem_next  = dem_wide[AW-1:0];

    assign dem_c     = CW'(dem_next);
    assign lim_c     = $signed({{(CW-LIMIT_W){1'b0}}, limit});
    assign neg_lim   = -lim_c;
    assign clamp_c   = (dem_c > lim_c) ? lim_c : ((dem_c < neg_lim) ? neg_lim : dem_c);
    assign cmd_next  = clamp_c[AW-1:0];

    assign cmd_e     = $signed({cmd_next[AW-1], cmd_next});
    assign pos_e     = $signed({pos[AW-1], pos});
    assign delta     = cmd_e - pos_e;
    assign err_next  = delta[AW] ? $unsigned(-delta) : $unsigned(delta);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_reg <= '0;
            dem_reg <= '0;
        end
        else
        begin
            if (ctrl.capture_src)
            begin
                src_reg <= dem_reg;
            end
            if (ctrl.fin_en)
            begin
                dem_reg <= dem_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.mul_en)
        begin
            prod_reg <= prod_next;
        end
        if (ctrl.fin_en)
        begin
            cmd_reg             <= cmd_next;
            err_reg             <= err_next;
            flag_reg.limited    <= (clamp_c != dem_c);
            flag_reg.cmd_le_pos <= (cmd_e <= pos_e);
            flag_reg.cmd_ge_pos <= (cmd_e >= pos_e);
        end
    end

    assign cmd  = cmd_reg;
    assign err  = err_reg;
    assign flag = flag_reg;

endmodule

// ===== sv/scsl_merge.sv =====
// merges the lane results into status, maximum error and the result fields
module scsl_merge #(
    parameter int ANGLE_WIDTH = 16
) (
    input  logic signed [ANGLE_WIDTH-1:0]   lane_cmd [scsl_pkg::NUM_LANES],
    input  logic [ANGLE_WIDTH:0]            lane_err [scsl_pkg::NUM_LANES],
    input  scsl_pkg::lane_flag_t            lane_flag [scsl_pkg::NUM_LANES],
    input  logic [scsl_pkg::FLAGS_W-1:0]    status_flags,
    input  logic                            held_law,
    input  logic                            blending,
    input  logic [scsl_pkg::TOL_W-1:0]      tolerance,
    input  logic                            frame_bad,
    output logic signed [ANGLE_WIDTH-1:0]   cmd_stab,
    output logic signed [ANGLE_WIDTH-1:0]   cmd_flap,
    output logic signed [ANGLE_WIDTH-1:0]   cmd_rudder,
    output logic                            active_law,
    output logic                            in_transition,
    output logic                            elec_saturated,
    output logic                            act_saturated,
    output logic                            protect_exhausted,
    output logic                            tracking_ok,
    output logic [scsl_pkg::ERR_W-1:0]      max_track_error,
    output logic                            frame_error
);
    import scsl_pkg::*;

    localparam int EW = ANGLE_WIDTH + 1;
    localparam int MW = (EW > ERR_W) ? EW : ERR_W;

    logic [EW-1:0]  max01;
    logic [EW-1:0]  max012;
    logic [MW-1:0]  max_ext;
    logic [MW-1:0]  tol_ext;
    logic [MW-1:0]  stab_err_ext;
    logic           any_lim;
    logic           law_sat;
    logic           protect;
    logic           at_lim;
    logic           stab_ok;
    logic [1:0]     dir;

    assign max01        = (lane_err[LANE_FLAP] > lane_err[LANE_STAB]) ?
                          lane_err[LANE_FLAP] : lane_err[LANE_STAB];
    assign max012       = (lane_err[LANE_RUDDER] > max01) ? lane_err[LANE_RUDDER] : max01;
    assign max_ext      = MW'(max012);
    assign tol_ext      = MW'(tolerance);
    assign stab_err_ext = MW'(lane_err[LANE_STAB]);

    assign any_lim = lane_flag[LANE_STAB].limited | lane_flag[LANE_FLAP].limited
                   | lane_flag[LANE_RUDDER].limited;
    assign law_sat = !held_law && status_flags[FLAG_LAW_SAT];
    assign protect = status_flags[FLAG_AOA] | status_flags[FLAG_NZ] | status_flags[FLAG_RATE];
    assign stab_ok = (stab_err_ext <= tol_ext);
    assign dir     = status_flags[FLAG_DIR_LO +: 2];

    // stab sits at its commanded limit only for a known direction
    always_comb
    begin
        at_lim = 1'b0;
        if (status_flags[FLAG_STAB_LIM])
        begin
            unique case (dir)
                DIR_NEG: at_lim = lane_flag[LANE_STAB].cmd_le_pos;
                DIR_POS: at_lim = lane_flag[LANE_STAB].cmd_ge_pos;
                default: at_lim = 1'b0;
            endcase
        end
    end

    always_comb
    begin
        active_law    = held_law;
        in_transition = blending;
        frame_error   = frame_bad;
        if (frame_bad)
        begin
            cmd_stab          = '0;
            cmd_flap          = '0;
            cmd_rudder        = '0;
            elec_saturated    = 1'b0;
            act_saturated     = 1'b0;
            protect_exhausted = 1'b0;
            tracking_ok       = 1'b0;
            max_track_error   = '0;
        end
        else
        begin
            cmd_stab          = lane_cmd[LANE_STAB];
            cmd_flap          = lane_cmd[LANE_FLAP];
            cmd_rudder        = lane_cmd[LANE_RUDDER];
            elec_saturated    = any_lim || law_sat;
            act_saturated     = status_flags[FLAG_ACT_SAT];
            protect_exhausted = protect &&
                                (lane_flag[LANE_STAB].limited || law_sat || (at_lim && !stab_ok));
            tracking_ok       = (max_ext <= tol_ext);
            max_track_error   = (max_ext > MW'({ERR_W{1'b1}})) ? {ERR_W{1'b1}} : max_ext[ERR_W-1:0];
        end
    end

endmodule

// ===== sv/surface_command_selector_limiter_unit.sv =====
// top level of the surface command selector limiter
//
// Usage: one item on the demand channel per control frame carries both demand
// sets, the law selection, measured positions, frame time and status flags.
// One result leaves on the command channel for each item. Both channels
// transfer at a clock edge where valid and ready are high. Limits, tracking
// tolerance and the blend rate are written through cfg_we/cfg_index/cfg_data;
// the user must write them only while the block is idle; the block itself does not enforce this.
// Sequence: after an item is taken, the sequencer steps through the fraction increment
// multiply, the fraction update, the lane blend multiply, the lane add/clamp/error
// step and the merge into the output register; a zero frame time goes straight from
// the fraction increment multiply to the merge. A new item is taken only after the
// result of the last one is loaded into the output register.
// Three lanes, one per surface, run side by side; a merge stage combines them.
// Reset: limits 4096, tolerance 41, blend rate 256, blend complete, demands
// and blend sources zero, no law held yet.
// A stalled receiver holds the result in the output register; the next item
// is still taken and waits in its last step until the register frees.
`include "surface_command_selector_limiter_unit_macros.svh"

module surface_command_selector_limiter_unit #(
    parameter int ANGLE_WIDTH   = 16,
    parameter int FRACTION_BITS = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [scsl_pkg::CFG_ADDR_W-1:0]     cfg_index,
    input  logic [scsl_pkg::CFG_DATA_W-1:0]     cfg_data,
    scsl_in_if.sink                             demand,
    scsl_out_if.source                          command
);
    import scsl_pkg::*;

    localparam int AW        = ANGLE_WIDTH;
    localparam int FW        = FRACTION_BITS + 1;
    localparam int PRODW     = DT_W + INV_W;
    localparam int SUMW      = PRODW + 1;
    localparam int INC_SHIFT = 24 - FRACTION_BITS;
    localparam logic [FW-1:0] FRAC_ONE = FW'(1) << FRACTION_BITS;

    seq_state_t             state_reg;
    seq_state_t             state_next;

    logic [LIMIT_W-1:0]     limit_reg [NUM_LANES];
    logic [TOL_W-1:0]       tol_reg;
    logic [INV_W-1:0]       inv_reg;

    logic                   started_reg;
    logic                   held_law_reg;
    logic [FW-1:0]          frac_reg;
    logic [FW-1:0]          frac_next;

    logic                   sel_reg;
    logic signed [AW-1:0]   tgt_reg [NUM_LANES];
    logic signed [AW-1:0]   pos_reg [NUM_LANES];
    logic [DT_W-1:0]        dt_reg;
    logic [FLAGS_W-1:0]     flags_reg;
    logic [PRODW-1:0]       inc_prod_reg;

    logic                   out_valid_reg;
    logic signed [AW-1:0]   out_cmd_stab_reg;
    logic signed [AW-1:0]   out_cmd_flap_reg;
    logic signed [AW-1:0]   out_cmd_rudder_reg;
    logic                   out_active_law_reg;
    logic                   out_in_transition_reg;
    logic                   out_elec_sat_reg;
    logic                   out_act_sat_reg;
    logic                   out_protect_reg;
    logic                   out_tracking_ok_reg;
    logic [ERR_W-1:0]       out_max_err_reg;
    logic                   out_frame_error_reg;

    logic                   accept;
    logic                   dt_zero;
    logic                   law_change;
    logic                   out_load;
    logic [PRODW-1:0]       inc_val;
    logic [SUMW-1:0]        frac_sum;
    lane_ctrl_t             lane_ctrl;

    logic signed [AW-1:0]   lane_cmd  [NUM_LANES];
    logic [AW:0]            lane_err  [NUM_LANES];
    lane_flag_t             lane_flag [NUM_LANES];

    logic signed [AW-1:0]   m_cmd_stab;
    logic signed [AW-1:0]   m_cmd_flap;
    logic signed [AW-1:0]   m_cmd_rudder;
    logic                   m_active_law;
    logic                   m_in_transition;
    logic                   m_elec_sat;
    logic                   m_act_sat;
    logic                   m_protect;
    logic                   m_tracking_ok;
    logic [ERR_W-1:0]       m_max_err;
    logic                   m_frame_error;

    assign demand.ready = (state_reg == ST_IDLE);
    assign accept       = demand.valid && demand.ready;
    assign dt_zero      = (dt_reg == '0);
    assign law_change   = started_reg && (held_law_reg != sel_reg);
    assign out_load     = (state_reg == ST_OUT) && (!out_valid_reg || command.ready);

    assign inc_val  = inc_prod_reg >> INC_SHIFT;
    assign frac_sum = SUMW'(frac_reg) + SUMW'(inc_val);

    assign lane_ctrl.capture_src = (state_reg == ST_INC) && !dt_zero && law_change;
    assign lane_ctrl.mul_en      = (state_reg == ST_PROD);
    assign lane_ctrl.fin_en      = (state_reg == ST_LANE);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (demand.valid) state_next = ST_INC;
            ST_INC:  state_next = dt_zero ? ST_OUT : ST_FRAC;
            ST_FRAC: state_next = ST_PROD;
            ST_PROD: state_next = ST_LANE;
            ST_LANE: state_next = ST_OUT;
            ST_OUT:  if (out_load) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // a law change restarts the blend; the first increment lands in the same frame
    always_comb
    begin
        frac_next = frac_reg;
        if ((state_reg == ST_INC) && !dt_zero && law_change)
        begin
            frac_next = '0;
        end
        else if ((state_reg == ST_FRAC) && (frac_reg < FRAC_ONE))
        begin
            frac_next = (frac_sum > SUMW'(FRAC_ONE)) ? FRAC_ONE : frac_sum[FW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            limit_reg[LANE_STAB]   <= LIMIT_W'(4096);
            limit_reg[LANE_FLAP]   <= LIMIT_W'(4096);
            limit_reg[LANE_RUDDER] <= LIMIT_W'(4096);
            tol_reg      <= TOL_W'(41);
            inv_reg      <= INV_W'(256);
            started_reg  <= 1'b0;
            held_law_reg <= 1'b0;
            frac_reg     <= FRAC_ONE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            frac_reg  <= frac_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_STAB_LIMIT:   limit_reg[LANE_STAB]   <= cfg_data[LIMIT_W-1:0];
                    REG_FLAP_LIMIT:   limit_reg[LANE_FLAP]   <= cfg_data[LIMIT_W-1:0];
                    REG_RUDDER_LIMIT: limit_reg[LANE_RUDDER] <= cfg_data[LIMIT_W-1:0];
                    REG_TRACK_TOL:    tol_reg <= cfg_data[TOL_W-1:0];
                    REG_INV_BLEND:    inv_reg <= cfg_data[INV_W-1:0];
                    default:          ;
                endcase
            end
            if ((state_reg == ST_INC) && !dt_zero)
            begin
                started_reg  <= 1'b1;
                held_law_reg <= sel_reg;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (command.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            sel_reg   <= demand.law_select;
            tgt_reg[LANE_STAB]   <= demand.law_select ? demand.dir_stab   : demand.norm_stab;
            tgt_reg[LANE_FLAP]   <= demand.law_select ? demand.dir_flap   : demand.norm_flap;
            tgt_reg[LANE_RUDDER] <= demand.law_select ? demand.dir_rudder : demand.norm_rudder;
            pos_reg[LANE_STAB]   <= demand.pos_stab;
            pos_reg[LANE_FLAP]   <= demand.pos_flap;
            pos_reg[LANE_RUDDER] <= demand.pos_rudder;
            dt_reg    <= demand.frame_time;
            flags_reg <= demand.status_flags;
        end
        if (state_reg == ST_INC)
        begin
            inc_prod_reg <= dt_reg * inv_reg;
        end
        if (out_load)
        begin
            out_cmd_stab_reg      <= m_cmd_stab;
            out_cmd_flap_reg      <= m_cmd_flap;
            out_cmd_rudder_reg    <= m_cmd_rudder;
            out_active_law_reg    <= m_active_law;
            out_in_transition_reg <= m_in_transition;
            out_elec_sat_reg      <= m_elec_sat;
            out_act_sat_reg       <= m_act_sat;
            out_protect_reg       <= m_protect;
            out_tracking_ok_reg   <= m_tracking_ok;
            out_max_err_reg       <= m_max_err;
            out_frame_error_reg   <= m_frame_error;
        end
    end

    for (genvar i = 0; i < NUM_LANES; i++)
    begin : g_lane
        scsl_lane #(
            .ANGLE_WIDTH   (ANGLE_WIDTH),
            .FRACTION_BITS (FRACTION_BITS)
        ) u_lane (
            .clk    (clk),
            .rst_n  (rst_n),
            .ctrl   (lane_ctrl),
            .target (tgt_reg[i]),
            .pos    (pos_reg[i]),
            .frac   (frac_reg),
            .limit  (limit_reg[i]),
            .cmd    (lane_cmd[i]),
            .err    (lane_err[i]),
            .flag   (lane_flag[i])
        );
    end

    scsl_merge #(
        .ANGLE_WIDTH (ANGLE_WIDTH)
    ) u_merge (
        .lane_cmd          (lane_cmd),
        .lane_err          (lane_err),
        .lane_flag         (lane_flag),
        .status_flags      (flags_reg),
        .held_law          (held_law_reg),
        .blending          (frac_reg < FRAC_ONE),
        .tolerance         (tol_reg),
        .frame_bad         (dt_zero),
        .cmd_stab          (m_cmd_stab),
        .cmd_flap          (m_cmd_flap),
        .cmd_rudder        (m_cmd_rudder),
        .active_law        (m_active_law),
        .in_transition     (m_in_transition),
        .elec_saturated    (m_elec_sat),
        .act_saturated     (m_act_sat),
        .protect_exhausted (m_protect),
        .tracking_ok       (m_tracking_ok),
        .max_track_error   (m_max_err),
        .frame_error       (m_frame_error)
    );

    assign command.valid             = out_valid_reg;
    assign command.cmd_stab          = out_cmd_stab_reg;
    assign command.cmd_flap          = out_cmd_flap_reg;
    assign command.cmd_rudder        = out_cmd_rudder_reg;
    assign command.active_law        = out_active_law_reg;
    assign command.in_transition     = out_in_transition_reg;
    assign command.elec_saturated    = out_elec_sat_reg;
    assign command.act_saturated     = out_act_sat_reg;
    assign command.protect_exhausted = out_protect_reg;
    assign command.tracking_ok       = out_tracking_ok_reg;
    assign command.max_track_error   = out_max_err_reg;
    assign command.frame_error       = out_frame_error_reg;

    `SCSL_ASSERT(a_state_onehot, $onehot(state_reg), "sequencer state is not one-hot")
    // one frame in flight: the input closes right after a transfer
    `SCSL_ASSERT_NEXT(a_one_in_flight, demand.valid && demand.ready, !demand.ready, "input open right after a transfer")
    `SCSL_ASSERT_NEXT(a_result_held, command.valid && !command.ready, command.valid && $stable(command.max_track_error) && $stable(command.cmd_stab), "stalled result changed")
    `SCSL_ASSERT(a_frac_bound, frac_reg <= FRAC_ONE, "blend fraction above one")
endmodule

// ===== test/tb.sv =====
// testbench for the surface command selector limiter: predicted commands checked per transfer
`timescale 1ns / 100ps

module tb;
    import scsl_pkg::*;

    localparam int     ANGLE_W        = 16;
    localparam int     FRAC_BITS      = 16;
    localparam longint FRAC_ONE       = longint'(1) << FRAC_BITS;
    localparam int     INC_SHIFT      = 24 - FRAC_BITS;
    localparam int     ERR_MAX        = 65535;
    localparam int     NUM_REGS       = 5;
    localparam int     NUM_PHASES     = 8;
    localparam int     CLK_PERIOD     = 10;
    localparam int     SETTLE_CYCLES  = 12;
    localparam int     WATCHDOG_LIMIT = 2000;
    localparam int     MAX_REPORTS    = 10;

    // register indexes with no register behind them
    localparam logic [CFG_ADDR_W-1:0] SPARE_IDX_LO = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] SPARE_IDX_HI = 3'd7;

    localparam logic [FLAGS_W-1:0] F_AOA      = 8'h01 << FLAG_AOA;
    localparam logic [FLAGS_W-1:0] F_NZ       = 8'h01 << FLAG_NZ;
    localparam logic [FLAGS_W-1:0] F_RATE     = 8'h01 << FLAG_RATE;
    localparam logic [FLAGS_W-1:0] F_LAW_SAT  = 8'h01 << FLAG_LAW_SAT;
    localparam logic [FLAGS_W-1:0] F_ACT_SAT  = 8'h01 << FLAG_ACT_SAT;
    localparam logic [FLAGS_W-1:0] F_STAB_LIM = 8'h01 << FLAG_STAB_LIM;
    localparam logic [FLAGS_W-1:0] F_DIR_NEG  = 8'(DIR_NEG) << FLAG_DIR_LO;
    localparam logic [FLAGS_W-1:0] F_DIR_POS  = 8'(DIR_POS) << FLAG_DIR_LO;

    typedef struct packed {
        logic                      law_select;
        logic signed [ANGLE_W-1:0] norm_stab;
        logic signed [ANGLE_W-1:0] norm_flap;
        logic signed [ANGLE_W-1:0] norm_rudder;
        logic signed [ANGLE_W-1:0] dir_stab;
        logic signed [ANGLE_W-1:0] dir_flap;
        logic signed [ANGLE_W-1:0] dir_rudder;
        logic signed [ANGLE_W-1:0] pos_stab;
        logic signed [ANGLE_W-1:0] pos_flap;
        logic signed [ANGLE_W-1:0] pos_rudder;
        logic [DT_W-1:0]           frame_time;
        logic [FLAGS_W-1:0]        status_flags;
    } frame_t;

    typedef struct packed {
        logic signed [ANGLE_W-1:0] cmd_stab;
        logic signed [ANGLE_W-1:0] cmd_flap;
        logic signed [ANGLE_W-1:0] cmd_rudder;
        logic                      active_law;
        logic                      in_transition;
        logic                      elec_saturated;
        logic                      act_saturated;
        logic                      protect_exhausted;
        logic                      tracking_ok;
        logic [ERR_W-1:0]          max_track_error;
        logic                      frame_error;
    } command_t;

    class command_predictor;
        logic [LIMIT_W-1:0] limit [NUM_LANES];
        logic [TOL_W-1:0]   tolerance;
        logic [INV_W-1:0]   blend_rate;

        bit     started;
        bit     held_law;
        longint blend_frac;
        longint blend_src [NUM_LANES];
        longint demand [NUM_LANES];

        command_t expected_commands [$];

        int errors;
        int frames_seen;
        int results_seen;
        int zero_time_frames;
        int blend_results;
        int sat_results;

        function new();
            int i;
            for (i = 0; i < NUM_LANES; i++)
            begin
                limit[i]     = 15'd4096;
                blend_src[i] = 0;
                demand[i]    = 0;
            end
            tolerance  = 16'd41;
            blend_rate = 16'd256;
            started    = 1'b0;
            held_law   = 1'b0;
            blend_frac = FRAC_ONE;
        endfunction

        function void write_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_STAB_LIMIT:   limit[LANE_STAB]   = data[LIMIT_W-1:0];
                REG_FLAP_LIMIT:   limit[LANE_FLAP]   = data[LIMIT_W-1:0];
                REG_RUDDER_LIMIT: limit[LANE_RUDDER] = data[LIMIT_W-1:0];
                REG_TRACK_TOL:    tolerance          = data;
                REG_INV_BLEND:    blend_rate         = data;
                default: ;
            endcase
        endfunction

        function void take_frame(frame_t f);
            command_t    e;
            int          tgt [NUM_LANES];
            int          pos [NUM_LANES];
            int          cmd [NUM_LANES];
            int          err [NUM_LANES];
            bit          clipped [NUM_LANES];
            int          lim;
            int          worst;
            int          i;
            longint      step_inc;
            longint      frac_next;
            bit          any_clip;
            bit          law_sat;
            bit          at_stop;
            bit          stab_in_tol;
            logic [1:0]  dir;
            e = '0;
            frames_seen++;
            if (f.frame_time == '0)
            begin
                // state frozen, only the held law, blend status and frame error show
                zero_time_frames++;
                e.active_law    = held_law;
                e.in_transition = blend_frac < FRAC_ONE;
                e.frame_error   = 1'b1;
                expected_commands.push_back(e);
                return;
            end
            tgt[LANE_STAB]   = f.law_select ? int'(f.dir_stab)   : int'(f.norm_stab);
            tgt[LANE_FLAP]   = f.law_select ? int'(f.dir_flap)   : int'(f.norm_flap);
            tgt[LANE_RUDDER] = f.law_select ? int'(f.dir_rudder) : int'(f.norm_rudder);
            pos[LANE_STAB]   = int'(f.pos_stab);
            pos[LANE_FLAP]   = int'(f.pos_flap);
            pos[LANE_RUDDER] = int'(f.pos_rudder);

            if (!started)
            begin
                held_law = f.law_select;
                for (i = 0; i < NUM_LANES; i++)
                    demand[i] = tgt[i];
                started = 1'b1;
            end
            else if (held_law != f.law_select)
            begin
                held_law = f.law_select;
                for (i = 0; i < NUM_LANES; i++)
                    blend_src[i] = demand[i];
                blend_frac = 0;
            end

            if (blend_frac >= FRAC_ONE)
            begin
                for (i = 0; i < NUM_LANES; i++)
                    demand[i] = tgt[i];
            end
            else
            begin
                step_inc  = (longint'(f.frame_time) * longint'(blend_rate)) >>> INC_SHIFT;
                frac_next = blend_frac + step_inc;
                if (frac_next > FRAC_ONE)
                    frac_next = FRAC_ONE;
                blend_frac = frac_next;
                // floor of the scaled difference, also for negative steps
                for (i = 0; i < NUM_LANES; i++)
                    demand[i] = blend_src[i]
                        + (((longint'(tgt[i]) - blend_src[i]) * blend_frac) >>> FRAC_BITS);
            end

            any_clip = 1'b0;
            worst    = 0;
            for (i = 0; i < NUM_LANES; i++)
            begin
                lim = int'(limit[i]);
                if (demand[i] > lim)
                    cmd[i] = lim;
                else if (demand[i] < -lim)
                    cmd[i] = -lim;
                else
                    cmd[i] = int'(demand[i]);
                clipped[i] = (cmd[i] != demand[i]);
                any_clip   = any_clip | clipped[i];
                err[i]     = (cmd[i] >= pos[i]) ? cmd[i] - pos[i] : pos[i] - cmd[i];
                if (err[i] > worst)
                    worst = err[i];
            end

            law_sat     = !held_law && f.status_flags[FLAG_LAW_SAT];
            dir         = f.status_flags[FLAG_DIR_LO +: 2];
            stab_in_tol = err[LANE_STAB] <= int'(tolerance);
            at_stop     = f.status_flags[FLAG_STAB_LIM]
                && ((dir == DIR_NEG && cmd[LANE_STAB] <= pos[LANE_STAB])
                 || (dir == DIR_POS && cmd[LANE_STAB] >= pos[LANE_STAB]));

            e.cmd_stab          = ANGLE_W'(cmd[LANE_STAB]);
            e.cmd_flap          = ANGLE_W'(cmd[LANE_FLAP]);
            e.cmd_rudder        = ANGLE_W'(cmd[LANE_RUDDER]);
            e.active_law        = held_law;
            e.in_transition     = blend_frac < FRAC_ONE;
            e.elec_saturated    = any_clip || law_sat;
            e.act_saturated     = f.status_flags[FLAG_ACT_SAT];
            e.protect_exhausted = (f.status_flags[FLAG_RATE:FLAG_AOA] != '0)
                && (clipped[LANE_STAB] || law_sat || (at_stop && !stab_in_tol));
            e.tracking_ok       = worst <= int'(tolerance);
            e.max_track_error   = (worst > ERR_MAX) ? ERR_W'(ERR_MAX) : ERR_W'(worst);
            e.frame_error       = 1'b0;
            if (e.in_transition)
                blend_results++;
            if (e.elec_saturated)
                sat_results++;
            expected_commands.push_back(e);
        endfunction

        function void check_field(string name, logic [15:0] want, logic [15:0] got);
            if (got !== want)
            begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("mismatch in command %0d, %s: expected %h, got %h",
                             results_seen, name, want, got);
            end
        endfunction

        function void match_command(command_t got);
            command_t want;
            results_seen++;
            if (expected_commands.size() == 0)
            begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("command %0d transferred with no frame behind it", results_seen);
                return;
            end
            want = expected_commands.pop_front();
            check_field("cmd_stab", want.cmd_stab, got.cmd_stab);
            check_field("cmd_flap", want.cmd_flap, got.cmd_flap);
            check_field("cmd_rudder", want.cmd_rudder, got.cmd_rudder);
            check_field("active_law", want.active_law, got.active_law);
            check_field("in_transition", want.in_transition, got.in_transition);
            check_field("elec_saturated", want.elec_saturated, got.elec_saturated);
            check_field("act_saturated", want.act_saturated, got.act_saturated);
            check_field("protect_exhausted", want.protect_exhausted, got.protect_exhausted);
            check_field("tracking_ok", want.tracking_ok, got.tracking_ok);
            check_field("max_track_error", want.max_track_error, got.max_track_error);
            check_field("frame_error", want.frame_error, got.frame_error);
        endfunction
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_ADDR_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    scsl_in_if  #(.ANGLE_WIDTH(ANGLE_W)) demand_ch ();
    scsl_out_if #(.ANGLE_WIDTH(ANGLE_W)) command_ch ();

    surface_command_selector_limiter_unit #(
        .ANGLE_WIDTH   (ANGLE_W),
        .FRACTION_BITS (FRAC_BITS)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .demand    (demand_ch),
        .command   (command_ch)
    );

    command_predictor pred;
    bit               cur_sel;
    int               tx_burst;
    int               quiet_cycles;

    always #(CLK_PERIOD / 2) clk = ~clk;

    function automatic int rand_angle();
        logic signed [ANGLE_W-1:0] v;
        case ($urandom_range(0, 3))
            0:
            begin
                v = ANGLE_W'($urandom);
                return int'(v);
            end
            1: return int'($urandom_range(0, 12000)) - 6000;
            2:
            begin
                case ($urandom_range(0, 3))
                    0: return -32768;
                    1: return 32767;
                    2: return -32767;
                    default: return 0;
                endcase
            end
            default:
                return int'($urandom_range(0, 64)) - 32
                    + ($urandom_range(0, 1) ? 4096 : -4096);
        endcase
    endfunction

    // a position close to the demand, kept inside the angle range
    function automatic int near(int v);
        int p;
        p = v + int'($urandom_range(0, 96)) - 48;
        if (p > 32767)
            p = 32767;
        if (p < -32768)
            p = -32768;
        return p;
    endfunction

    function automatic frame_t frame_of(bit sel, int ts, int tf, int tr,
                                        int ps, int pf, int pr,
                                        int dt, logic [FLAGS_W-1:0] flags);
        frame_t f;
        f.law_select   = sel;
        f.norm_stab    = ANGLE_W'(sel ? rand_angle() : ts);
        f.norm_flap    = ANGLE_W'(sel ? rand_angle() : tf);
        f.norm_rudder  = ANGLE_W'(sel ? rand_angle() : tr);
        f.dir_stab     = ANGLE_W'(sel ? ts : rand_angle());
        f.dir_flap     = ANGLE_W'(sel ? tf : rand_angle());
        f.dir_rudder   = ANGLE_W'(sel ? tr : rand_angle());
        f.pos_stab     = ANGLE_W'(ps);
        f.pos_flap     = ANGLE_W'(pf);
        f.pos_rudder   = ANGLE_W'(pr);
        f.frame_time   = DT_W'(dt);
        f.status_flags = flags;
        return f;
    endfunction

    function automatic frame_t rand_frame(bit sel);
        frame_t f;
        int     ts;
        int     tf;
        int     tr;
        int     dt;
        ts = rand_angle();
        tf = rand_angle();
        tr = rand_angle();
        case ($urandom_range(0, 15))
            0:       dt = 0;
            1:       dt = 65535;
            2, 3, 4: dt = int'($urandom_range(1, 65535));
            default: dt = int'($urandom_range(1, 4096));
        endcase
        if ($urandom_range(0, 1))
            f = frame_of(sel, ts, tf, tr, near(ts), near(tf), near(tr), dt,
                         FLAGS_W'($urandom_range(0, 255)));
        else
            f = frame_of(sel, ts, tf, tr, rand_angle(), rand_angle(), rand_angle(), dt,
                         FLAGS_W'($urandom_range(0, 255)));
        return f;
    endfunction

    task automatic send_frame(frame_t f);
        int gap;
        if (tx_burst > 0)
        begin
            gap = 0;
            tx_burst--;
        end
        else
        begin
            gap = $urandom_range(0, 15);
            if ($urandom_range(0, 19) == 0)
                tx_burst = $urandom_range(10, 40);
        end
        if (gap > 0)
        begin
            demand_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        demand_ch.valid        <= 1'b1;
        demand_ch.law_select   <= f.law_select;
        demand_ch.norm_stab    <= f.norm_stab;
        demand_ch.norm_flap    <= f.norm_flap;
        demand_ch.norm_rudder  <= f.norm_rudder;
        demand_ch.dir_stab     <= f.dir_stab;
        demand_ch.dir_flap     <= f.dir_flap;
        demand_ch.dir_rudder   <= f.dir_rudder;
        demand_ch.pos_stab     <= f.pos_stab;
        demand_ch.pos_flap     <= f.pos_flap;
        demand_ch.pos_rudder   <= f.pos_rudder;
        demand_ch.frame_time   <= f.frame_time;
        demand_ch.status_flags <= f.status_flags;
        do
            @(posedge clk);
        while (!demand_ch.ready);
        pred.take_frame(f);
    endtask

    // stop sending and let every outstanding command drain out
    task automatic settle();
        demand_ch.valid <= 1'b0;
        @(posedge clk);
        while (pred.expected_commands.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic apply_settings(logic [15:0] stab, logic [15:0] flap, logic [15:0] rudder,
                                  logic [15:0] tol, logic [15:0] rate);
        logic [CFG_DATA_W-1:0] vals [NUM_REGS];
        logic [CFG_ADDR_W-1:0] spare;
        logic [CFG_DATA_W-1:0] junk;
        int                    i;
        vals[REG_STAB_LIMIT]   = stab;
        vals[REG_FLAP_LIMIT]   = flap;
        vals[REG_RUDDER_LIMIT] = rudder;
        vals[REG_TRACK_TOL]    = tol;
        vals[REG_INV_BLEND]    = rate;
        cfg_we <= 1'b1;
        for (i = 0; i < NUM_REGS; i++)
        begin
            cfg_index <= i[CFG_ADDR_W-1:0];
            cfg_data  <= vals[i];
            pred.write_reg(i[CFG_ADDR_W-1:0], vals[i]);
            @(posedge clk);
        end
        // a write to an unused index must not touch any register
        spare = CFG_ADDR_W'($urandom_range(SPARE_IDX_LO, SPARE_IDX_HI));
        junk  = CFG_DATA_W'($urandom_range(0, 65535));
        cfg_index <= spare;
        cfg_data  <= junk;
        pred.write_reg(spare, junk);
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic run_random(int count);
        int n;
        for (n = 0; n < count; n++)
        begin
            if ($urandom_range(0, 7) == 0)
                cur_sel = ~cur_sel;
            if ($urandom_range(0, 79) == 0)
                settle();
            send_frame(rand_frame(cur_sel));
        end
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
            quiet_cycles <= 0;
        else if ((demand_ch.valid && demand_ch.ready) || (command_ch.valid && command_ch.ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog: no transfer for %0d cycles", quiet_cycles);
            $display("TEST FAILED");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin : command_sink
        int       stall;
        int       burst;
        command_t got;
        burst = 0;
        command_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (burst > 0)
            begin
                stall = 0;
                burst--;
            end
            else
            begin
                stall = $urandom_range(0, 15);
                if ($urandom_range(0, 19) == 0)
                    burst = $urandom_range(10, 40);
            end
            if (stall > 0)
            begin
                command_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            command_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (!command_ch.valid);
            got.cmd_stab          = command_ch.cmd_stab;
            got.cmd_flap          = command_ch.cmd_flap;
            got.cmd_rudder        = command_ch.cmd_rudder;
            got.active_law        = command_ch.active_law;
            got.in_transition     = command_ch.in_transition;
            got.elec_saturated    = command_ch.elec_saturated;
            got.act_saturated     = command_ch.act_saturated;
            got.protect_exhausted = command_ch.protect_exhausted;
            got.tracking_ok       = command_ch.tracking_ok;
            got.max_track_error   = command_ch.max_track_error;
            got.frame_error       = command_ch.frame_error;
            pred.match_command(got);
        end
    end

    initial
    begin : stimulus
        int phase;
        pred     = new();
        cur_sel  = 1'b0;
        tx_burst = 0;
        rst_n                  <= 1'b0;
        cfg_we                 <= 1'b0;
        cfg_index              <= '0;
        cfg_data               <= '0;
        demand_ch.valid        <= 1'b0;
        demand_ch.law_select   <= 1'b0;
        demand_ch.norm_stab    <= '0;
        demand_ch.norm_flap    <= '0;
        demand_ch.norm_rudder  <= '0;
        demand_ch.dir_stab     <= '0;
        demand_ch.dir_flap     <= '0;
        demand_ch.dir_rudder   <= '0;
        demand_ch.pos_stab     <= '0;
        demand_ch.pos_flap     <= '0;
        demand_ch.pos_rudder   <= '0;
        demand_ch.frame_time   <= '0;
        demand_ch.status_flags <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // zero frame time before the first valid frame
        send_frame(frame_of(1, 100, 200, 300, 0, 0, 0, 0, 8'hFF));
        // first frame takes the direct target at once, clamped both ways
        send_frame(frame_of(1, 32767, -32768, 1000, 32767, -32768, 1000, 256, 0));
        send_frame(frame_of(1, 4096, -4096, 0, 4096, -4096, 0, 100, F_ACT_SAT));
        // law saturation ignored while direct law is held
        send_frame(frame_of(1, 4097, -4097, 41, 4000, -4000, 0, 100, F_LAW_SAT));
        // change to normal law starts a blend
        send_frame(frame_of(0, -2000, 2000, 500, -2000, 2000, 500, 16384, 0));
        send_frame(frame_of(0, -2000, 2000, 500, -2000, 2000, 500, 0, 0));
        send_frame(frame_of(0, -2000, 2000, 500, -2000, 2000, 500, 16384, F_NZ));
        // change back in the middle of a blend
        send_frame(frame_of(1, 3000, -3000, -500, 0, 0, 0, 1, 0));
        send_frame(frame_of(1, 3000, -3000, -500, 3000, -3000, -500, 65535, 0));
        // protection with the stab clamped
        send_frame(frame_of(1, 5000, 0, 0, 5000, 0, 0, 1000, F_AOA));
        // stab held at its stop in either direction
        send_frame(frame_of(1, 1000, 0, 0, 2000, 0, 0, 1000, F_NZ | F_STAB_LIM | F_DIR_NEG));
        send_frame(frame_of(1, 1000, 0, 0, 0, 0, 0, 1000, F_RATE | F_STAB_LIM | F_DIR_POS));
        send_frame(frame_of(1, 1000, 0, 0, 2000, 0, 0, 1000,
                            F_AOA | F_STAB_LIM | F_DIR_NEG | F_DIR_POS));
        send_frame(frame_of(1, 1000, 0, 0, 2000, 0, 0, 1000, F_AOA | F_STAB_LIM));
        send_frame(frame_of(1, 1000, 0, 0, 1000, 0, 0, 1000, F_AOA | F_STAB_LIM | F_DIR_NEG));
        // normal law with law saturation, long frame leaves the blend one step short
        send_frame(frame_of(0, 100, 100, 100, 100, 100, 100, 65535, F_AOA | F_LAW_SAT));
        send_frame(frame_of(0, 100, 100, 100, 100, 100, 100, 1, F_LAW_SAT));
        // positions at the far ends of the range
        send_frame(frame_of(0, -32768, 32767, 0, 32767, -32768, -32768, 1, 0));
        send_frame(frame_of(0, 0, 0, 0, 0, 0, 0, 0, 8'hFF));
        send_frame(frame_of(0, 41, -41, 0, 0, 0, 0, 65535, 8'hFF));
        cur_sel = 1'b0;
        run_random(250);

        for (phase = 1; phase < NUM_PHASES; phase++)
        begin
            settle();
            case (phase)
                1: apply_settings(16'd0, 16'd0, 16'd0, 16'd0, 16'd1);
                2:
                begin
                    // bit 15 of a limit write is dropped
                    apply_settings(16'hFFFF, 16'd32767, 16'd32767, 16'd65535, 16'd65535);
                    send_frame(frame_of(cur_sel, 32767, -32768, 0, -32768, 32767, 0, 65535, 0));
                    send_frame(frame_of(cur_sel, 32767, -32768, 0, -32768, 32767, 0, 65535, 0));
                end
                default:
                    apply_settings(16'($urandom_range(0, 65535)),
                                   16'($urandom_range(0, 1) ? $urandom_range(256, 8192)
                                                            : $urandom_range(0, 32767)),
                                   16'($urandom_range(0, 32767)),
                                   16'($urandom_range(0, 1) ? $urandom_range(0, 200)
                                                            : $urandom_range(0, 65535)),
                                   16'($urandom_range(0, 1) ? $urandom_range(1, 2048)
                                                            : $urandom_range(1, 65535)));
            endcase
            run_random(235);
        end
        settle();

        $display("covered %0d frames over %0d register settings: %0d zero frame times,",
                 pred.frames_seen, NUM_PHASES, pred.zero_time_frames);
        $display("%0d commands while blending, %0d saturated, %0d commands checked, %0d mismatches",
                 pred.blend_results, pred.sat_results, pred.results_seen, pred.errors);
        if (pred.expected_commands.size() != 0)
            $display("%0d commands never arrived", pred.expected_commands.size());
        if (pred.errors == 0 && pred.expected_commands.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule
